// ----- design/sters_pkg.sv -----
// ----------------------------------------------------------------------------
// sters_pkg: shared types and constants for the equal-range search block
// Table geometry, field widths and the control/status bundles that pass
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package sters_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned DATA_W      = 32;

  // Operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Strobes from the sequencer, already qualified by their conditions
  typedef struct packed {
    logic init;     // load key and bounds for the leftward search
    logic probe;    // latch midpoint and read the table there
    logic compare;  // narrow the range from the read word
    logic swap;     // save the first match, restart for the rightward search
    logic emit;     // load the result register
  } ctl_t;

  // Status from the datapath back to the sequencer
  typedef struct packed {
    logic range_empty;  // lo has passed hi, current search is finished
    logic dir_right;    // the rightward search is running
    logic out_blocked;  // result register full and not taken this cycle
  } stat_t;

endpackage

// ----- design/sters_seq.sv -----
// ----------------------------------------------------------------------------
// sters_seq: microcoded sequencer
// A five-step program in a read-only table. Each control word names one
// datapath action, a jump condition and the two successor steps.
// ----------------------------------------------------------------------------
module sters_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sters_pkg::stat_t stat_i,
  output sters_pkg::ctl_t  ctl_o,
  output logic             idle_o
);
  import sters_pkg::*;

  typedef logic [2:0] step_t;

  typedef enum logic [2:0] {
    ACT_INIT,
    ACT_PROBE,
    ACT_COMPARE,
    ACT_SWAP,
    ACT_EMIT
  } act_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_RANGE_EMPTY,
    COND_DIR_RIGHT,
    COND_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t on_true;
    step_t on_false;
  } uword_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_PROBE = 3'd1;
  localparam step_t STEP_CMP   = 3'd2;
  localparam step_t STEP_SWAP  = 3'd3;
  localparam step_t STEP_EMIT  = 3'd4;

  // Control store
  function automatic uword_t rom(input step_t step);
    uword_t w;
    case (step)
      STEP_IDLE:  w = '{ACT_INIT,    COND_START,       STEP_PROBE, STEP_IDLE};
      STEP_PROBE: w = '{ACT_PROBE,   COND_RANGE_EMPTY, STEP_SWAP,  STEP_CMP};
      STEP_CMP:   w = '{ACT_COMPARE, COND_ALWAYS,      STEP_PROBE, STEP_PROBE};
      STEP_SWAP:  w = '{ACT_SWAP,    COND_DIR_RIGHT,   STEP_EMIT,  STEP_PROBE};
      STEP_EMIT:  w = '{ACT_EMIT,    COND_OUT_BLOCKED, STEP_EMIT,  STEP_IDLE};
      default:    w = '{ACT_INIT,    COND_ALWAYS,      STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

  step_t  step_q, step_d;
  uword_t uw;
  logic   cond_met;

  assign uw = rom(step_q);

  // Condition select
  always_comb begin
    case (uw.cond)
      COND_ALWAYS:      cond_met = 1'b1;
      COND_START:       cond_met = start_i;
      COND_RANGE_EMPTY: cond_met = stat_i.range_empty;
      COND_DIR_RIGHT:   cond_met = stat_i.dir_right;
      COND_OUT_BLOCKED: cond_met = stat_i.out_blocked;
      default:          cond_met = 1'b1;
    endcase
  end

  assign step_d = cond_met ? uw.on_true : uw.on_false;

  // Action decode; init, probe, swap and emit are qualified by their conditions
  always_comb begin
    ctl_o         = '0;
    ctl_o.init    = (uw.act == ACT_INIT) && start_i;
    ctl_o.probe   = (uw.act == ACT_PROBE) && !stat_i.range_empty;
    ctl_o.compare = (uw.act == ACT_COMPARE);
    ctl_o.swap    = (uw.act == ACT_SWAP) && !stat_i.dir_right;
    ctl_o.emit    = (uw.act == ACT_EMIT) && !stat_i.out_blocked;
  end

  assign idle_o = (step_q == STEP_IDLE);

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- design/sters_dp.sv -----
// ----------------------------------------------------------------------------
// sters_dp: search datapath
// Entry table, count register, search bounds, compare and result register.
// ----------------------------------------------------------------------------
module sters_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sters_pkg::ctl_t                      ctl_i,
  output sters_pkg::stat_t                     stat_o,
  input  logic                                 cfg_we_i,
  input  logic [sters_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  logic                                 wr_en_i,
  input  logic [7:0]                           entry_index_i,
  input  logic signed [sters_pkg::DATA_W-1:0]  entry_value_i,
  input  logic signed [sters_pkg::DATA_W-1:0]  search_key_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic [7:0]                           first_index_o,
  output logic [7:0]                           last_index_o
);
  import sters_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // Table storage, no reset
  logic signed [DATA_W-1:0] mem_q [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_sat;
  logic signed [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]         lo_q, lo_d;
  logic [CNT_W-1:0]         end_q, end_d;   // exclusive upper bound
  logic [IDX_W-1:0]         mid_q, mid_c;
  logic [CNT_W:0]           mid_sum;
  logic [IDX_W-1:0]         hit_q, hit_d;
  logic                     hit_vld_q, hit_vld_d;
  logic                     dir_right_q, dir_right_d;
  logic [IDX_W-1:0]         first_q;
  logic                     first_vld_q;
  logic                     out_valid_q;
  logic                     found_q;
  logic [IDX_W-1:0]         first_out_q, last_out_q;
  logic                     wr_hit;

  // Table write and registered probe read
  assign wr_hit = wr_en_i && ({1'b0, entry_index_i} < 9'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[entry_index_i[IDX_W-1:0]] <= entry_value_i;
    end
    if (ctl_i.probe) begin
      rd_data_q <= mem_q[mid_c];
    end
  end

  // Count register, saturated at the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign count_sat = (count_q > DEPTH_CNT) ? DEPTH_CNT : count_q;

  // Lower-middle probe of [lo, end)
  assign mid_sum = {1'b0, lo_q} + {1'b0, end_q} - (CNT_W+1)'(1);
  assign mid_c   = mid_sum[IDX_W:1];

  // Bound update
  always_comb begin
    lo_d        = lo_q;
    end_d       = end_q;
    hit_d       = hit_q;
    hit_vld_d   = hit_vld_q;
    dir_right_d = dir_right_q;
    if (ctl_i.init) begin
      lo_d        = '0;
      end_d       = count_sat;
      hit_vld_d   = 1'b0;
      dir_right_d = 1'b0;
    end else if (ctl_i.swap) begin
      lo_d        = '0;
      end_d       = count_sat;
      hit_vld_d   = 1'b0;
      dir_right_d = 1'b1;
    end else if (ctl_i.compare) begin
      if (rd_data_q == key_q) begin
        hit_d     = mid_q;
        hit_vld_d = 1'b1;
        if (dir_right_q) begin
          lo_d = {1'b0, mid_q} + CNT_W'(1);
        end else begin
          end_d = {1'b0, mid_q};
        end
      end else if (rd_data_q > key_q) begin
        end_d = {1'b0, mid_q};
      end else begin
        lo_d = {1'b0, mid_q} + CNT_W'(1);
      end
    end
  end

  // Search control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q        <= '0;
      end_q       <= '0;
      hit_vld_q   <= 1'b0;
      dir_right_q <= 1'b0;
      first_vld_q <= 1'b0;
    end else begin
      lo_q        <= lo_d;
      end_q       <= end_d;
      hit_vld_q   <= hit_vld_d;
      dir_right_q <= dir_right_d;
      if (ctl_i.swap) begin
        first_vld_q <= hit_vld_q;
      end
    end
  end

  // Search payload
  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    if (ctl_i.init) begin
      key_q <= search_key_i;
    end
    if (ctl_i.probe) begin
      mid_q <= mid_c;
    end
    if (ctl_i.swap) begin
      first_q <= hit_vld_q ? hit_q : '0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ctl_i.emit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      found_q     <= first_vld_q || hit_vld_q;
      first_out_q <= first_q;
      last_out_q  <= hit_vld_q ? hit_q : '0;
    end
  end

  assign stat_o.range_empty = (lo_q >= end_q);
  assign stat_o.dir_right   = dir_right_q;
  assign stat_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign first_index_o = 8'(first_out_q);
  assign last_index_o  = 8'(last_out_q);

endmodule

// ----- design/sorted_table_equal_range_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search: first and last match in a sorted table
// A write item stores one signed 32-bit entry; a query item runs a leftward
// and a rightward binary search over the first entry_count entries and
// reports found, first index and last index (indices 0 when not found).
// ----------------------------------------------------------------------------
// A write item is taken while the block is idle and gives no result. A query
// runs on a five-step microprogram: each probe of the table takes a probe
// step (a registered read of the table) and then a compare step, each search
// ends with one empty-range check and one swap step, and one step loads the
// result. Each search probes the table at most 9 times for 256 entries, and
// the load of the result waits while an earlier result is stalled.
// Input items are held off while a query runs. The result sits in an output
// register, so the next item is taken while a finished result waits.
// entry_count is written through cfg_we_i/cfg_wdata_i while the block is
// idle; counts above 256 are treated as 256. Entries read by a query must
// have been written first.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [sters_pkg::CNT_W-1:0]          cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic [7:0]                           entry_index_i,
  input  logic signed [sters_pkg::DATA_W-1:0]  entry_value_i,
  input  logic signed [sters_pkg::DATA_W-1:0]  search_key_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic [7:0]                           first_index_o,
  output logic [7:0]                           last_index_o
);
  import sters_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  idle;
  logic  in_xfer;
  logic  query_start;
  logic  wr_en;

  // Input transfer decode
  assign in_stall_o  = !idle;
  assign in_xfer     = in_valid_i && idle;
  assign query_start = in_xfer && (operation_i == OP_QUERY);
  assign wr_en       = in_xfer && (operation_i == OP_WRITE);

  sters_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (query_start),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .idle_o  (idle)
  );

  sters_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .wr_en_i       (wr_en),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .first_index_o (first_index_o),
    .last_index_o  (last_index_o)
  );

endmodule

// ----- sim/sorted_table_equal_range_search_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search_tb: self-checking bench for the search block
// Loads the table through write transfers and then runs first/last-match
// queries under many entry_count settings. Idle gaps and stalls are random on
// both channels. A scoreboard keeps its own copy of the table and the count,
// predicts each query's result and checks every output transfer in order.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search_tb;
  import sters_pkg::*;

  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int ITEM_TARGET    = 650;
  localparam int SETTLE_CYCLES  = 50;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic       found;
    logic [7:0] first_idx;
    logic [7:0] last_idx;
  } match_result_t;

  // Scoreboard: mirror of the table and count, queue of predicted matches
  class range_scoreboard;
    logic signed [DATA_W-1:0] entry_mem [TABLE_DEPTH];
    logic [CNT_W-1:0]         entry_count;
    match_result_t            match_q [$];
    int                       error_count;

    function new();
      entry_count = '0;
      error_count = 0;
      foreach (entry_mem[i]) entry_mem[i] = '0;
    endfunction

    function void set_count(logic [CNT_W-1:0] cnt);
      entry_count = cnt;
    endfunction

    function int pending();
      return match_q.size();
    endfunction

    // Lower-middle binary search; on a hit keep the index and move on
    function int search_side(logic signed [DATA_W-1:0] key, int cnt, bit go_right);
      int lo;
      int hi;
      int mid;
      int hit;
      lo  = 0;
      hi  = cnt - 1;
      hit = -1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (entry_mem[mid] == key) begin
          hit = mid;
          if (go_right) lo = mid + 1;
          else hi = mid - 1;
        end else if (entry_mem[mid] > key) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      return hit;
    endfunction

    // Accepted input transfer: update the table or queue a prediction
    function void note_item(logic op, logic [7:0] idx, logic signed [DATA_W-1:0] val,
                            logic signed [DATA_W-1:0] key);
      int cnt;
      int first;
      int last;
      match_result_t res;
      if (op == OP_WRITE) begin
        entry_mem[idx] = val;
      end else begin
        cnt   = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        first = search_side(key, cnt, 1'b0);
        last  = search_side(key, cnt, 1'b1);
        res.found     = (first >= 0) || (last >= 0);
        res.first_idx = (first >= 0) ? first[7:0] : 8'd0;
        res.last_idx  = (last >= 0) ? last[7:0] : 8'd0;
        match_q.push_back(res);
      end
    endfunction

    // Accepted output transfer: compare with the oldest prediction
    function void check_result(logic found, logic [7:0] first_idx, logic [7:0] last_idx);
      match_result_t exp_res;
      if (match_q.size() == 0) begin
        $display("%0t ERROR unexpected result: found %0b first %0d last %0d",
                 $time, found, first_idx, last_idx);
        error_count++;
        return;
      end
      exp_res = match_q.pop_front();
      if (found !== exp_res.found) begin
        $display("%0t ERROR found: expected %0b, actual %0b", $time, exp_res.found, found);
        error_count++;
      end
      if (first_idx !== exp_res.first_idx) begin
        $display("%0t ERROR first_index: expected %0d, actual %0d",
                 $time, exp_res.first_idx, first_idx);
        error_count++;
      end
      if (last_idx !== exp_res.last_idx) begin
        $display("%0t ERROR last_index: expected %0d, actual %0d",
                 $time, exp_res.last_idx, last_idx);
        error_count++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CNT_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     operation_i;
  logic [7:0]               entry_index_i;
  logic signed [DATA_W-1:0] entry_value_i;
  logic signed [DATA_W-1:0] search_key_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     found_o;
  logic [7:0]               first_index_o;
  logic [7:0]               last_index_o;

  range_scoreboard          sb = new();
  logic signed [DATA_W-1:0] shadow_mem [TABLE_DEPTH];  // table as driven, for key picks
  bit                       steady = 1'b0;              // no gaps and no stalls
  int                       items_sent = 0;
  int                       stall_left = 0;
  int                       idle_cycles = 0;

  sorted_table_equal_range_search u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .first_index_o (first_index_o),
    .last_index_o  (last_index_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Monitor: transfers, config writes and the watchdog, all at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_item(operation_i, entry_index_i, entry_value_i, search_key_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(found_o, first_index_o, last_index_o);
        stall_left = steady ? 0 : $urandom_range(0, 8);
      end
      if (cfg_we_i) sb.set_count(cfg_wdata_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ERROR watchdog: no transfer for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: hold stall for the drawn number of cycles that a result waits
  always @(negedge clk_i) begin
    out_stall_i <= (stall_left > 0);
    if (out_valid_o && stall_left > 0) stall_left--;
  end

  // One input transfer after a random gap; valid stays high into the next item
  task automatic send_item(input logic op, input logic [7:0] idx,
                           input logic signed [DATA_W-1:0] val,
                           input logic signed [DATA_W-1:0] key);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    entry_index_i <= idx;
    entry_value_i <= val;
    search_key_i  <= key;
    if (op == OP_WRITE) shadow_mem[idx] = val;
    items_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Unused fields carry random values
  task automatic write_entry(input logic [7:0] idx, input logic signed [DATA_W-1:0] val);
    send_item(OP_WRITE, idx, val, $urandom);
  endtask

  task automatic query_key(input logic signed [DATA_W-1:0] key);
    send_item(OP_QUERY, 8'($urandom_range(0, 255)), $urandom, key);
  endtask

  // Stop sending, let all results come out, then give the block time to settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic start_phase(input int unsigned cnt);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(cnt);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Nondecreasing run from index 0, with repeats for equal ranges
  task automatic fill_sorted(input int n, input longint base, input int unsigned max_step);
    longint v;
    v = base;
    for (int i = 0; i < n; i++) begin
      write_entry(i[7:0], v[31:0]);
      if ($urandom_range(0, 2) != 0) v += $urandom_range(1, max_step);
      if (v > longint'(KEY_MAX)) v = longint'(KEY_MAX);
    end
  endtask

  // Mostly keys present in the live range, some neighbors, extremes and noise
  function automatic logic signed [DATA_W-1:0] pick_key(input int n);
    int                       r;
    logic signed [DATA_W-1:0] v;
    r = $urandom_range(0, 9);
    if (n == 0 || r == 9) return $urandom;
    if (r == 8) return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
    v = shadow_mem[$urandom_range(0, n - 1)];
    if (r >= 6) return $urandom_range(0, 1) ? v + 1 : v - 1;
    return v;
  endfunction

  initial begin
    int unsigned cnt;
    int          live;
    int          n_items;
    int          r;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    operation_i   = OP_WRITE;
    entry_index_i = '0;
    entry_value_i = '0;
    search_key_i  = '0;
    out_stall_i   = 1'b0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Count still zero from reset: nothing is probed
    query_key($urandom);

    // Whole table, sorted from the most negative value up to a run of maximums
    fill_sorted(TABLE_DEPTH, longint'(KEY_MIN), 32'd1 << 26);

    // Full table: both extremes, a present key, its neighbor, zero
    start_phase(TABLE_DEPTH);
    query_key(KEY_MIN);
    query_key(KEY_MAX);
    query_key(shadow_mem[100]);
    query_key(shadow_mem[100] + 1);
    query_key(0);

    // Count above the depth saturates to the full table
    start_phase(511);
    query_key(shadow_mem[200]);
    query_key(KEY_MIN);

    // Single entry in use
    start_phase(1);
    query_key(shadow_mem[0]);
    query_key(KEY_MAX);

    // Zero count with a written table
    start_phase(0);
    query_key(shadow_mem[0]);

    // Unsorted prefix, last index written too
    start_phase(5);
    write_entry(8'd2, KEY_MAX);
    write_entry(8'd3, KEY_MIN);
    write_entry(8'd255, 0);
    query_key(KEY_MAX);
    query_key(KEY_MIN);
    query_key(shadow_mem[0]);

    // Two equal entries: first and last differ
    start_phase(2);
    write_entry(8'd0, 7);
    write_entry(8'd1, 7);
    query_key(7);
    query_key(8);

    // Random phases: new count, optional fresh sorted prefix, then queries
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       cnt = 0;
        1, 2, 3: cnt = $urandom_range(1, 8);
        4, 5:    cnt = $urandom_range(9, 40);
        6:       cnt = $urandom_range(41, 255);
        7:       cnt = TABLE_DEPTH;
        8:       cnt = $urandom_range(TABLE_DEPTH + 1, 511);
        default: cnt = $urandom_range(1, 64);
      endcase
      start_phase(cnt);
      steady = ($urandom_range(0, 3) == 0);
      live   = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
      if (cnt > 0 && cnt <= 64 && $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 2))
          0:       fill_sorted(live, longint'($signed(32'($urandom))), 1);
          1:       fill_sorted(live, longint'($signed(32'($urandom))), 3);
          default: fill_sorted(live, longint'($signed(32'($urandom))), 1000);
        endcase
      end
      n_items = $urandom_range(4, 14);
      repeat (n_items) begin
        // Occasional stray write anywhere in the table
        if ($urandom_range(0, 9) == 0)
          write_entry(8'($urandom_range(0, 255)), $urandom);
        else
          query_key(pick_key(live));
      end
    end

    drain();
    if (sb.error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
